### hw/rtl/ffrl_pkg.sv
// shared types, constants and helpers for the first fault record latch
// depends on nothing; imported by every module of the block
package ffrl_pkg;

   localparam int FRAME_WORDS = 8;
   localparam logic [32:0] FRAME_BYTES = 33'(FRAME_WORDS * 4);

   localparam logic [31:0] REC_MAGIC = 32'h424D_5346;
   localparam logic [31:0] REC_XOR   = 32'hA55A_3CC3;

   localparam logic [31:0] REGION_BASE_RESET  = 32'h2000_0000;
   localparam logic [31:0] REGION_BYTES_RESET = 32'(144 * 1024);

   localparam int CODE_W  = 15;
   localparam int SEQ_W   = 16;
   localparam int KIND_W  = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [KIND_W-1:0] KIND_RESTORE    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TRIP       = 2'd1;
   localparam logic [KIND_W-1:0] KIND_HARD_FAULT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_REGION_BASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_BYTES = 2'd1;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CODE_W-1:0] code;
      logic [31:0]       context_req;
      logic [31:0]       tick;
      logic [31:0]       frame_addr;
      logic [31:0]       stacked_lr;
      logic [31:0]       stacked_pc;
      logic [31:0]       bkp_magic;
      logic [31:0]       bkp_word1;
      logic [31:0]       bkp_payload0;
      logic [31:0]       bkp_payload1;
      logic [31:0]       bkp_checksum;
   } req_type;

   typedef struct packed {
      logic              write_record;
      logic [31:0]       rec_word1;
      logic [31:0]       rec_payload0;
      logic [31:0]       rec_payload1;
      logic [31:0]       rec_checksum;
      logic              force_standby;
      logic              frame_ok;
      logic              latched;
      logic              prev_valid;
      logic [SEQ_W-1:0]  prev_sequence;
      logic [CODE_W-1:0] prev_code;
      logic              prev_frame_valid;
   } rsp_type;

   typedef struct packed {
      logic [31:0] base;
      logic [31:0] bytes;
   } region_type;

   function automatic logic [31:0] rec_sum(input logic [31:0] w1,
                                           input logic [31:0] p0,
                                           input logic [31:0] p1);
      rec_sum = REC_MAGIC ^ w1 ^ p0 ^ p1 ^ REC_XOR;
   endfunction

endpackage

### hw/rtl/ffrl_csr.sv
// region configuration registers, plain write port, no read-back
// depends on ffrl_pkg
module ffrl_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [ffrl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_wdata,
   output ffrl_pkg::region_type          region
);
   import ffrl_pkg::*;

   logic [31:0] base_ff;
   logic [31:0] bytes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= REGION_BASE_RESET;
         bytes_ff <= REGION_BYTES_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_REGION_BASE:  base_ff  <= csr_wdata;
            CSR_REGION_BYTES: bytes_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign region.base  = base_ff;
   assign region.bytes = bytes_ff;

endmodule

### hw/rtl/ffrl_input_stage.sv
// input register stage: holds one request word until the core takes it
// depends on ffrl_pkg
module ffrl_input_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ffrl_pkg::req_type req_word,
   input  logic              take,
   output logic              stage_valid,
   output ffrl_pkg::req_type item
);
   import ffrl_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;

   assign req_ready = !valid_ff || take;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_word;
      end
   end

   assign stage_valid = valid_ff;
   assign item        = item_ff;

endmodule

### hw/rtl/ffrl_core.sv
// record formatting logic and the latch / previous-record state
// depends on ffrl_pkg
module ffrl_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  ffrl_pkg::req_type    item,
   input  ffrl_pkg::region_type region,
   output ffrl_pkg::rsp_type    result
);
   import ffrl_pkg::*;

   logic              latched_ff,    latched_in;
   logic              prev_valid_ff, prev_valid_in;
   logic [SEQ_W-1:0]  prev_seq_ff,   prev_seq_in;
   logic [CODE_W-1:0] prev_code_ff,  prev_code_in;
   logic              prev_frame_ff, prev_frame_in;

   logic              restore_ok;
   logic              frame_pass;
   logic [32:0]       frame_last;
   logic [32:0]       region_end;
   logic [SEQ_W-1:0]  next_seq;
   logic [31:0]       w1;
   logic [31:0]       p0;
   logic [31:0]       p1;

   // region check at 33 bits so neither sum wraps
   assign frame_last = {1'b0, item.frame_addr} + FRAME_BYTES;
   assign region_end = {1'b0, region.base} + {1'b0, region.bytes};
   assign frame_pass = (item.frame_addr[1:0] == 2'b00) && (item.frame_addr >= region.base)
                       && (frame_last <= region_end);

   assign restore_ok = (item.bkp_magic == REC_MAGIC) &&
                       (item.bkp_checksum ==
                        rec_sum(item.bkp_word1, item.bkp_payload0, item.bkp_payload1));

   assign next_seq = prev_valid_ff ? SEQ_W'(prev_seq_ff + 1'b1) : SEQ_W'(1);

   always_comb begin
      latched_in    = latched_ff;
      prev_valid_in = prev_valid_ff;
      prev_seq_in   = prev_seq_ff;
      prev_code_in  = prev_code_ff;
      prev_frame_in = prev_frame_ff;
      result        = '0;
      w1            = '0;
      p0            = '0;
      p1            = '0;
      case (item.kind)
         KIND_RESTORE: begin
            prev_valid_in = restore_ok;
            if (restore_ok) begin
               prev_seq_in   = item.bkp_word1[31:16];
               prev_code_in  = item.bkp_word1[CODE_W-1:0];
               prev_frame_in = item.bkp_word1[15];
            end
         end
         KIND_TRIP, KIND_HARD_FAULT: begin
            result.force_standby = 1'b1;
            result.frame_ok      = (item.kind == KIND_HARD_FAULT) && frame_pass;
            if (!latched_ff) begin
               latched_in          = 1'b1;
               w1                  = {next_seq, result.frame_ok, item.code};
               p0                  = result.frame_ok ? item.stacked_pc : item.context_req;
               p1                  = result.frame_ok ? item.stacked_lr : item.tick;
               result.write_record = 1'b1;
               result.rec_word1    = w1;
               result.rec_payload0 = p0;
               result.rec_payload1 = p1;
               result.rec_checksum = rec_sum(w1, p0, p1);
            end
         end
         default: ;
      endcase
      result.latched          = latched_in;
      result.prev_valid       = prev_valid_in;
      result.prev_sequence    = prev_seq_in;
      result.prev_code        = prev_code_in;
      result.prev_frame_valid = prev_frame_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latched_ff    <= 1'b0;
         prev_valid_ff <= 1'b0;
         prev_seq_ff   <= '0;
         prev_code_ff  <= '0;
         prev_frame_ff <= 1'b0;
      end else if (fire) begin
         latched_ff    <= latched_in;
         prev_valid_ff <= prev_valid_in;
         prev_seq_ff   <= prev_seq_in;
         prev_code_ff  <= prev_code_in;
         prev_frame_ff <= prev_frame_in;
      end
   end

endmodule

### hw/rtl/ffrl_output_stage.sv
// result register: holds one response word until the consumer takes it
// depends on ffrl_pkg
module ffrl_output_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  ffrl_pkg::rsp_type result,
   output logic              space,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ffrl_pkg::rsp_type rsp_word
);
   import ffrl_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type word_ff;

   assign space    = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

### hw/rtl/first_fault_record_latch.sv
// top level of the first fault record latch
// depends on ffrl_pkg, ffrl_csr, ffrl_input_stage, ffrl_core, ffrl_output_stage
//
// takes one request word per cycle while the output side is not stalled and
// returns exactly one response word for it: the word is registered on entry, the
// record is formatted in a single pass of compares, one 16-bit increment and xors,
// and the response is registered on exit. throughput is one word per clock, set
// by that single combinational pass; the output register lets a new word enter
// while the previous response still waits. a restore word checks a backup record
// and keeps its sequence, code and frame flag; the first trip or hard fault after
// reset latches and emits a new record, later ones only request standby. the user
// writes region_base and region_bytes through the csr port only while the block
// is idle; the block itself does not enforce this. no clearing pass is needed after reset.
module first_fault_record_latch (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  ffrl_pkg::req_type             req_word,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ffrl_pkg::rsp_type             rsp_word,
   // configuration write port
   input  logic                          csr_write_en,
   input  logic [ffrl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_wdata
);
   import ffrl_pkg::*;

   region_type region;
   req_type    item;
   rsp_type    result;
   logic       stage_valid;
   logic       out_space;
   logic       fire;

   // the staged word moves on whenever the result register is free or draining
   assign fire = stage_valid && out_space;

   // region registers
   ffrl_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .region       (region)
   );

   // entry register
   ffrl_input_stage u_input (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .take        (fire),
      .stage_valid (stage_valid),
      .item        (item)
   );

   // record formatting and latch state, state commits only when the word moves on
   ffrl_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (item),
      .region (region),
      .result (result)
   );

   // exit register
   ffrl_output_stage u_output (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .result    (result),
      .space     (out_space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

### hw/rtl/ffrl_checker.sv
// port-level checks for the first fault record latch, bound to the top level
// depends on ffrl_pkg and first_fault_record_latch
module ffrl_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input ffrl_pkg::rsp_type             rsp_word
);
   import ffrl_pkg::*;

   // a stalled response holds its word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("response changed while stalled");

   // nothing is offered in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // an empty output side never blocks a request
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty output");

   // a delivered record write leaves no second record write behind it
   a_single_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_word.write_record
      |=> !(rsp_valid && rsp_word.write_record))
      else $error("second record write after latch");

   // a record write comes only with standby and the latch set
   a_write_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.write_record |-> rsp_word.force_standby && rsp_word.latched)
      else $error("record write without standby or latch");

endmodule

bind first_fault_record_latch ffrl_checker u_checker (.*);

### tb/sv/ffrl_record_checker.sv
// response checker for the first fault record latch: tracks the region registers,
// predicts the response to every accepted request word and compares field by field
// depends on ffrl_pkg for the word types, the kind and register codes and the record constants
module ffrl_record_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  ffrl_pkg::req_type              req_word,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  ffrl_pkg::rsp_type              rsp_word,
   input  logic                           csr_write_en,
   input  logic [ffrl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_wdata,
   output int                             mismatch_count,
   output int                             responses_owed
);
   import ffrl_pkg::*;

   // shadow of the block state and of the region registers
   logic              fault_seen;
   logic              prev_ok;
   logic [SEQ_W-1:0]  prev_seq;
   logic [CODE_W-1:0] prev_code;
   logic              prev_frame;
   logic [31:0]       region_base_q;
   logic [31:0]       region_bytes_q;

   rsp_type owed_responses[$];
   rsp_type oldest;

   // response to one request word; advances the shadow state
   function automatic rsp_type fault_record_response(input req_type w);
      rsp_type          r;
      logic [32:0]      frame_last;
      logic [32:0]      region_last;
      logic [SEQ_W-1:0] seq;
      logic             good;
      r = '0;
      case (w.kind)
         KIND_RESTORE: begin
            good = (w.bkp_magic == REC_MAGIC) &&
                   (w.bkp_checksum == (REC_MAGIC ^ w.bkp_word1 ^ w.bkp_payload0 ^
                                       w.bkp_payload1 ^ REC_XOR));
            prev_ok = good;
            if (good) begin
               prev_seq   = w.bkp_word1[31:16];
               prev_frame = w.bkp_word1[15];
               prev_code  = w.bkp_word1[CODE_W-1:0];
            end
         end
         KIND_TRIP, KIND_HARD_FAULT: begin
            r.force_standby = 1'b1;
            if (w.kind == KIND_HARD_FAULT) begin
               frame_last  = {1'b0, w.frame_addr} + 33'(FRAME_WORDS * 4);
               region_last = {1'b0, region_base_q} + {1'b0, region_bytes_q};
               r.frame_ok  = (w.frame_addr[1:0] == 2'b00) &&
                             (w.frame_addr >= region_base_q) && (frame_last <= region_last);
            end
            if (!fault_seen) begin
               seq = prev_ok ? prev_seq + 16'd1 : 16'd1;
               fault_seen     = 1'b1;
               r.write_record = 1'b1;
               r.rec_word1    = {seq, r.frame_ok, w.code};
               r.rec_payload0 = r.frame_ok ? w.stacked_pc : w.context_req;
               r.rec_payload1 = r.frame_ok ? w.stacked_lr : w.tick;
               r.rec_checksum = REC_MAGIC ^ r.rec_word1 ^ r.rec_payload0 ^
                                r.rec_payload1 ^ REC_XOR;
            end
         end
         default: ;
      endcase
      r.latched          = fault_seen;
      r.prev_valid       = prev_ok;
      r.prev_sequence    = prev_seq;
      r.prev_code        = prev_code;
      r.prev_frame_valid = prev_frame;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch %s: expected %h got %h at %0t", name, want, got, $realtime);
      end
   endtask

   initial begin
      mismatch_count = 0;
      responses_owed = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         fault_seen     = 1'b0;
         prev_ok        = 1'b0;
         prev_seq       = '0;
         prev_code      = '0;
         prev_frame     = 1'b0;
         region_base_q  = REGION_BASE_RESET;
         region_bytes_q = REGION_BYTES_RESET;
         owed_responses.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_REGION_BASE:  region_base_q  = csr_wdata;
               CSR_REGION_BYTES: region_bytes_q = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            owed_responses.push_back(fault_record_response(req_word));
         if (rsp_valid && rsp_ready) begin
            if (owed_responses.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response word %h at %0t", rsp_word, $realtime);
            end else begin
               oldest = owed_responses.pop_front();
               check_field("write_record", 32'(oldest.write_record), 32'(rsp_word.write_record));
               check_field("rec_word1", oldest.rec_word1, rsp_word.rec_word1);
               check_field("rec_payload0", oldest.rec_payload0, rsp_word.rec_payload0);
               check_field("rec_payload1", oldest.rec_payload1, rsp_word.rec_payload1);
               check_field("rec_checksum", oldest.rec_checksum, rsp_word.rec_checksum);
               check_field("force_standby", 32'(oldest.force_standby),
                           32'(rsp_word.force_standby));
               check_field("frame_ok", 32'(oldest.frame_ok), 32'(rsp_word.frame_ok));
               check_field("latched", 32'(oldest.latched), 32'(rsp_word.latched));
               check_field("prev_valid", 32'(oldest.prev_valid), 32'(rsp_word.prev_valid));
               check_field("prev_sequence", 32'(oldest.prev_sequence),
                           32'(rsp_word.prev_sequence));
               check_field("prev_code", 32'(oldest.prev_code), 32'(rsp_word.prev_code));
               check_field("prev_frame_valid", 32'(oldest.prev_frame_valid),
                           32'(rsp_word.prev_frame_valid));
            end
         end
      end
      responses_owed = owed_responses.size();
   end

endmodule

### tb/sv/tb_top.sv
// top of the first fault record latch testbench: clock, reset, request stimulus,
// response back-pressure, region register writes and the final verdict
// depends on ffrl_pkg, first_fault_record_latch and ffrl_record_checker
module tb_top;
   import ffrl_pkg::*;

   // kind code the block leaves unused; it must report status and change nothing
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   // ways a restore word is built
   localparam int RESTORE_CLEAN     = 0;
   localparam int RESTORE_BAD_SUM   = 1;
   localparam int RESTORE_BAD_MAGIC = 2;

   localparam int PHASE_WORDS = 320;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_word;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_word;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_wdata;

   int mismatch_count;
   int responses_owed;

   // idle rates in percent and the receiver hold-off, shared with the receiver process
   int send_idle_pct;
   int rcv_idle_pct;
   int hold_cycles;

   // copy of the region registers, used to aim frame addresses at the edges
   logic [31:0] cur_base;
   logic [31:0] cur_bytes;

   first_fault_record_latch dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_word     (req_word),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_word     (rsp_word),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   ffrl_record_checker record_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_word       (req_word),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_word       (rsp_word),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .responses_owed (responses_owed)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // run limit, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   // receiver: random stalls, or a long hold-off counted down here
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready = 1'b0;
            hold_cycles = hold_cycles - 1;
         end else begin
            rsp_ready = ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   // turn a word into a restore of a backup record; the checksum is made to match
   // unless a flaw is asked for
   function automatic req_type as_restore(input req_type w, input logic [31:0] word1,
                                          input int flaw);
      w.kind         = KIND_RESTORE;
      w.bkp_magic    = REC_MAGIC;
      w.bkp_word1    = word1;
      w.bkp_checksum = REC_MAGIC ^ word1 ^ w.bkp_payload0 ^ w.bkp_payload1 ^ REC_XOR;
      if (flaw == RESTORE_BAD_SUM)
         w.bkp_checksum = w.bkp_checksum ^ (32'd1 << $urandom_range(31));
      else if (flaw == RESTORE_BAD_MAGIC)
         w.bkp_magic = REC_MAGIC ^ (32'd1 << $urandom_range(31));
      return w;
   endfunction

   // random request word; half of the restores are well formed, frame addresses mostly
   // land on or near the region edges
   function automatic req_type random_word();
      req_type w;
      int      pick;
      int      flaw;
      w.kind         = KIND_TRIP;
      w.code         = CODE_W'($urandom());
      w.context_req  = $urandom();
      w.tick         = $urandom();
      w.frame_addr   = $urandom();
      w.stacked_lr   = $urandom();
      w.stacked_pc   = $urandom();
      w.bkp_magic    = $urandom();
      w.bkp_word1    = $urandom();
      w.bkp_payload0 = $urandom();
      w.bkp_payload1 = $urandom();
      w.bkp_checksum = $urandom();
      pick = $urandom_range(99);
      if (pick < 30) begin
         flaw = $urandom_range(0, 3);
         if (flaw > RESTORE_BAD_MAGIC)
            flaw = RESTORE_CLEAN;
         w = as_restore(w, $urandom(), flaw);
      end else if (pick < 55) begin
         w.kind = KIND_TRIP;
      end else if (pick < 92) begin
         w.kind = KIND_HARD_FAULT;
         case ($urandom_range(4))
            0: w.frame_addr = cur_base + 32'(4 * $urandom_range(0, 63));
            1: w.frame_addr = cur_base + cur_bytes - 32'd40 + 32'(4 * $urandom_range(0, 4));
            2: w.frame_addr = cur_base - 32'(4 * $urandom_range(1, 4));
            3: w.frame_addr = cur_base + 32'($urandom_range(0, 255));
            default: ;
         endcase
         if ($urandom_range(9) == 0)
            w.frame_addr[1:0] = 2'($urandom_range(1, 3));
      end else begin
         w.kind = KIND_UNUSED;
      end
      return w;
   endfunction

   // offer one word; entered and left at a falling edge, valid stays high on exit
   task automatic send_word(input req_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_word  = w;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // stop offering and wait until every owed response has come back
   task automatic wait_drained();
      req_valid = 1'b0;
      while (responses_owed != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_region(input logic [31:0] base, input logic [31:0] bytes);
      csr_write_en = 1'b1;
      csr_index    = CSR_REGION_BASE;
      csr_wdata    = base;
      @(negedge clock);
      csr_index    = CSR_REGION_BYTES;
      csr_wdata    = bytes;
      @(negedge clock);
      csr_write_en = 1'b0;
      cur_base     = base;
      cur_bytes    = bytes;
   endtask

   initial begin : stimulus
      req_type     w;
      logic [31:0] probe_addr [6];
      // every input known from time zero
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_word      = '0;
      csr_write_en  = 1'b0;
      csr_index     = CSR_REGION_BASE;
      csr_wdata     = '0;
      send_idle_pct = 7;
      rcv_idle_pct  = 76;
      hold_cycles   = 0;
      cur_base      = REGION_BASE_RESET;
      cur_bytes     = REGION_BYTES_RESET;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // directed part, reset region settings
      // restore with a broken magic word leaves no earlier record
      w = random_word();
      w = as_restore(w, $urandom(), RESTORE_BAD_MAGIC);
      send_word(w);
      // unused kind with every field at both extremes
      w = '1;
      w.kind = KIND_UNUSED;
      send_word(w);
      w = '0;
      w.kind = KIND_UNUSED;
      send_word(w);
      // earlier record at the top sequence so the new record wraps to zero
      w = random_word();
      w = as_restore(w, 32'hFFFF_FFFF, RESTORE_CLEAN);
      send_word(w);
      // first fault: hard fault with its frame at the very start of the region
      w = random_word();
      w.kind       = KIND_HARD_FAULT;
      w.code       = '1;
      w.frame_addr = cur_base;
      send_word(w);
      // later trip only requests standby
      w = random_word();
      w.kind        = KIND_TRIP;
      w.code        = '0;
      w.context_req = '1;
      w.tick        = '1;
      send_word(w);
      // region check edges: last frame that fits, one word past the end,
      // just below the base, misaligned, top of memory, address zero
      probe_addr[0] = cur_base + cur_bytes - 32'd32;
      probe_addr[1] = cur_base + cur_bytes - 32'd28;
      probe_addr[2] = cur_base - 32'd4;
      probe_addr[3] = cur_base + 32'd2;
      probe_addr[4] = 32'hFFFF_FFFC;
      probe_addr[5] = 32'h0;
      foreach (probe_addr[i]) begin
         w = random_word();
         w.kind       = KIND_HARD_FAULT;
         w.frame_addr = probe_addr[i];
         send_word(w);
      end
      // failed restore clears only the valid flag
      w = random_word();
      w = as_restore(w, $urandom(), RESTORE_BAD_SUM);
      send_word(w);
      // restores after the latch still update the earlier record
      w = random_word();
      w = as_restore(w, 32'h0000_0000, RESTORE_CLEAN);
      send_word(w);
      w = random_word();
      w = as_restore(w, 32'h1234_7ABC, RESTORE_CLEAN);
      send_word(w);
      w = random_word();
      w.kind = KIND_TRIP;
      w.code = '1;
      send_word(w);

      // random part: one region setting per phase, extremes among them
      for (int phase = 0; phase < 5; phase++) begin
         wait_drained();
         case (phase)
            0: write_region($urandom() & 32'hFFFF_FFFC, 32'($urandom_range(0, 4096)));
            1: write_region(32'h0, 32'h0);
            2: write_region(32'hFFFF_FFE0, 32'hFFFF_FFFF);
            3: write_region(32'h0, 32'hFFFF_FFFF);
            default: write_region(32'hFFFF_FFFF, 32'h0);
         endcase
         // rare sender gaps and frequent receiver stalls first, then the reverse, then none
         if (phase < 2) begin
            send_idle_pct = 7;
            rcv_idle_pct  = 76;
         end else if (phase < 4) begin
            send_idle_pct = 76;
            rcv_idle_pct  = 7;
         end else begin
            send_idle_pct = 0;
            rcv_idle_pct  = 0;
         end
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // long receiver hold-off while words keep coming, so the block backs up
            if (phase == 4 && n == 100)
               hold_cycles = 80;
            send_word(random_word());
         end
      end

      wait_drained();
      if (mismatch_count == 0 && responses_owed == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

### first_fault_record_latch.f
hw/rtl/ffrl_pkg.sv
hw/rtl/ffrl_csr.sv
hw/rtl/ffrl_input_stage.sv
hw/rtl/ffrl_core.sv
hw/rtl/ffrl_output_stage.sv
hw/rtl/first_fault_record_latch.sv
hw/rtl/ffrl_checker.sv
tb/sv/ffrl_record_checker.sv
tb/sv/tb_top.sv
